FILE: rtl/b2d_pkg.sv
// shared types and constants for the binary to decimal ascii converter
// no dependencies; imported by b2d_cell and binary_to_decimal_ascii_core
package b2d_pkg;

    localparam int MAX_DIGITS    = 20;
    localparam int VALUE_W       = 64;
    localparam int BITS_PER_STEP = 4;
    localparam int STEPS         = VALUE_W / BITS_PER_STEP;
    localparam int STEP_W        = $clog2(STEPS);
    localparam int CNT_W         = $clog2(MAX_DIGITS + 1);
    localparam int CHAR_W        = 6;

    localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

    // one control word fans out to every digit cell
    typedef struct packed {
        logic clear;
        logic dabble;
        logic shift_digit;
    } cell_ctrl_t;

endpackage

FILE: rtl/b2d_cell.sv
// one bcd digit cell of the double dabble chain
// depends on b2d_pkg for the cell control word and step width
module b2d_cell (
    input  logic                                aclk,
    input  b2d_pkg::cell_ctrl_t                 ctrl,
    input  logic [b2d_pkg::BITS_PER_STEP-1:0]   carry_in,
    input  logic [3:0]                          digit_in,
    output logic [b2d_pkg::BITS_PER_STEP-1:0]   carry_out,
    output logic [3:0]                          digit_out
);
    import b2d_pkg::*;

    logic [3:0] digit_reg;
    logic [3:0] digit_next;
    logic [3:0] dab_digit;

    // add-3 correction then shift one bit in, once per bit of the step
    always_comb begin
        dab_digit = digit_reg;
        for (int j = 0; j < BITS_PER_STEP; j++) begin
            if (dab_digit >= 4'd5) begin
                dab_digit = dab_digit + 4'd3;
            end
            carry_out[j] = dab_digit[3];
            dab_digit    = {dab_digit[2:0], carry_in[j]};
        end
    end

    always_comb begin
        priority if (ctrl.clear) begin
            digit_next = 4'd0;
        end else if (ctrl.dabble) begin
            digit_next = dab_digit;
        end else if (ctrl.shift_digit) begin
            digit_next = digit_in;
        end else begin
            digit_next = digit_reg;
        end
    end

    always_ff @(posedge aclk) begin
        digit_reg <= digit_next;
    end

    assign digit_out = digit_reg;

endmodule

FILE: rtl/binary_to_decimal_ascii_core.sv
// top level: 64-bit unsigned binary to ascii decimal digits, most significant first
// depends on b2d_pkg and a chain of b2d_cell digit cells
//
//  channel   ports                              direction
//  input     s_valid s_ready s_value[63:0]      in
//  result    m_valid m_ready m_digit_char[5:0]  out
//            m_last
//
// a value is taken while idle, then double dabble runs over all 64 bits at 4 bits a cycle
// leading zeros are then shifted out of the cell chain one digit a cycle, the state hands
// over to output, then one digit a cycle goes to the output register whenever that register
// is empty or m_ready is high; s_ready stays low until the last digit is registered and the
// core is back in idle, so the next value cannot transfer before then
// m_ready low with a digit pending holds the chain during output; reset is synchronous, active low, and clears control
module binary_to_decimal_ascii_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [b2d_pkg::VALUE_W-1:0]       s_value,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [b2d_pkg::CHAR_W-1:0]        m_digit_char,
    output logic                              m_last
);
    import b2d_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_SKIP,
        ST_EMIT
    } state_t;

    state_t                state_reg;
    logic [VALUE_W-1:0]    value_reg;
    logic [STEP_W-1:0]     step_reg;
    logic [CNT_W-1:0]      remaining_reg;
    logic                  overflow_reg;
    logic                  m_valid_reg;
    logic [CHAR_W-1:0]     m_digit_char_reg;
    logic                  m_last_reg;

    cell_ctrl_t                 ctrl;
    logic [BITS_PER_STEP-1:0]   msb_bits;
    logic [BITS_PER_STEP-1:0]   carry [MAX_DIGITS+1];
    logic [3:0]                 digit [MAX_DIGITS+1];
    logic [3:0]                 top_digit;
    logic                       accept;
    logic                       emit;
    logic                       skip;

    assign accept    = s_valid && (state_reg == ST_IDLE);
    assign top_digit = digit[MAX_DIGITS];
    assign emit      = (state_reg == ST_EMIT) && (!m_valid_reg || m_ready);
    assign skip      = (state_reg == ST_SKIP) && !overflow_reg
                       && (top_digit == 4'd0) && (remaining_reg > CNT_W'(1));

    always_comb begin
        ctrl.clear       = accept;
        ctrl.dabble      = (state_reg == ST_CONV);
        ctrl.shift_digit = emit || skip;
    end

    // bits enter the bottom cell most significant first
    always_comb begin
        for (int j = 0; j < BITS_PER_STEP; j++) begin
            msb_bits[j] = value_reg[VALUE_W-1-j];
        end
    end
    assign carry[0] = msb_bits;
    assign digit[0] = 4'd0;

    for (genvar i = 0; i < MAX_DIGITS; i++) begin : g_cell
        b2d_cell u_cell (
            .aclk      (aclk),
            .ctrl      (ctrl),
            .carry_in  (carry[i]),
            .digit_in  (digit[i]),
            .carry_out (carry[i+1]),
            .digit_out (digit[i+1])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            remaining_reg <= '0;
            overflow_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && !emit) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        state_reg    <= ST_CONV;
                        step_reg     <= '0;
                        overflow_reg <= 1'b0;
                    end
                end
                ST_CONV: begin
                    // a carry out of the top cell means high digits were cut off
                    if (carry[MAX_DIGITS] != '0) begin
                        overflow_reg <= 1'b1;
                    end
                    step_reg <= step_reg + STEP_W'(1);
                    if (step_reg == STEP_W'(STEPS - 1)) begin
                        state_reg     <= ST_SKIP;
                        remaining_reg <= CNT_W'(MAX_DIGITS);
                    end
                end
                ST_SKIP: begin
                    if (skip) begin
                        remaining_reg <= remaining_reg - CNT_W'(1);
                    end else begin
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (emit) begin
                        m_valid_reg      <= 1'b1;
                        m_digit_char_reg <= ASCII_ZERO + CHAR_W'(top_digit);
                        m_last_reg       <= (remaining_reg == CNT_W'(1));
                        remaining_reg    <= remaining_reg - CNT_W'(1);
                        if (remaining_reg == CNT_W'(1)) begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            value_reg <= s_value;
        end else if (state_reg == ST_CONV) begin
            value_reg <= value_reg << BITS_PER_STEP;
        end
    end

    assign s_ready      = (state_reg == ST_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_digit_char = m_digit_char_reg;
    assign m_last       = m_last_reg;

    a_digit_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_digit_char_reg >= ASCII_ZERO)
                        && (m_digit_char_reg <= ASCII_ZERO + CHAR_W'(9)))
        else $error("digit character outside 0 to 9");

    a_remaining_live: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_SKIP) || (state_reg == ST_EMIT))
            |-> (remaining_reg != '0) && (remaining_reg <= CNT_W'(MAX_DIGITS)))
        else $error("digit count out of range during output");

    a_conv_done: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_CONV) && (step_reg == STEP_W'(STEPS - 1)))
            |=> (state_reg == ST_SKIP) && (remaining_reg == CNT_W'(MAX_DIGITS)))
        else $error("conversion did not hand over to digit output");

    a_last_ends_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit && (remaining_reg == CNT_W'(1))) |=> m_valid_reg && m_last_reg
                                                   && (state_reg == ST_IDLE))
        else $error("final digit not flagged as last");

endmodule
